### hdl/gsu_pkg.sv
// ----------------------------------------------------------------------------
// GSM septet unpacker package
// Shared types and the default-alphabet translation table.
// ----------------------------------------------------------------------------
package gsu_pkg;

   // One result item: a Latin-1 character, or the terminator flagged last.
   typedef struct packed {
      logic [7:0] character;
      logic       last;
   } result_type;

   // Reset value of the character limit register.
   localparam logic [7:0] MAX_CHARS_RESET = 8'd160;

   // Results that one accepted item can cause at most.
   localparam int unsigned MAX_RESULTS = 3;

   // Last position within a group of seven octets.
   localparam logic [2:0] LAST_PHASE = 3'd6;

   // GSM default alphabet to Latin-1. Codes with no Latin-1 form give '?'.
   localparam logic [7:0] SEPTET_ROM [128] = '{
      8'h40, 8'hA3, 8'h24, 8'hA5, 8'hE8, 8'hE9, 8'hF9, 8'hEC,
      8'hF2, 8'hC7, 8'h0A, 8'hD8, 8'hF8, 8'h0D, 8'hC5, 8'hE5,
      8'h3F, 8'h5F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F,
      8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'hC6, 8'hE6, 8'hDF, 8'hC9,
      8'h20, 8'h21, 8'h22, 8'h23, 8'hA4, 8'h25, 8'h26, 8'h27,
      8'h28, 8'h29, 8'h2A, 8'h2B, 8'h2C, 8'h2D, 8'h2E, 8'h2F,
      8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
      8'h38, 8'h39, 8'h3A, 8'h3B, 8'h3C, 8'h3D, 8'h3E, 8'h3F,
      8'hA1, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47,
      8'h48, 8'h49, 8'h4A, 8'h4B, 8'h4C, 8'h4D, 8'h4E, 8'h4F,
      8'h50, 8'h51, 8'h52, 8'h53, 8'h54, 8'h55, 8'h56, 8'h57,
      8'h58, 8'h59, 8'h5A, 8'hC4, 8'hD6, 8'hD1, 8'hDC, 8'hA7,
      8'hBF, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66, 8'h67,
      8'h68, 8'h69, 8'h6A, 8'h6B, 8'h6C, 8'h6D, 8'h6E, 8'h6F,
      8'h70, 8'h71, 8'h72, 8'h73, 8'h74, 8'h75, 8'h76, 8'h77,
      8'h78, 8'h79, 8'h7A, 8'hE4, 8'hF6, 8'hF1, 8'hFC, 8'hE0
   };

endpackage

### hdl/gsm_septet_unpacker_unit.sv
// ----------------------------------------------------------------------------
// GSM septet unpacker
// Turns a 7-bit packed SMS user-data stream into Latin-1 characters.
// ----------------------------------------------------------------------------
// Usage:
// The req channel carries one item per octet. An item with req_is_header set
// gives the septet count of a new message; this count is capped at the value
// in the csr register (160 after reset). Each following octet yields one
// character on the rsp channel, and every seventh octet of a group yields a
// second one from the carried bits. When the count is used up a NUL item with
// rsp_last set ends the message, and further octets are dropped until the
// next header. A header with a count of zero gives the NUL item alone.
// Results of an accepted item are registered in the queue. An item is taken in
// every cycle while the result queue has room for three results; the rsp side
// drains one result per cycle unless the receiver stalls, so the sustained
// rate is set by the number of results, eight per seven octets in a long message.
// When the receiver stalls, results wait in the eight-entry queue and
// req_stall rises once fewer than three entries are free.
// Reset is synchronous: it empties the queue, makes the block idle and sets
// the limit back to 160. Users write the csr register only while idle, unenforced.
// ----------------------------------------------------------------------------
module gsm_septet_unpacker_unit
   import gsu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   // Input items
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_octet,
   input  logic       req_is_header,
   // Result items
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_character,
   output logic       rsp_last,
   // Character limit register
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_data
);

   // Decoder state.
   logic [7:0] max_chars_ff, max_chars_in;
   logic [6:0] carry_ff, carry_in;
   logic [2:0] phase_ff, phase_in;
   logic [7:0] left_ff, left_in;
   logic       active_ff, active_in;

   // Result queue: eight entries, one read place, up to three writes per item.
   result_type queue_ff [8];
   logic [2:0] wr_ptr_ff, wr_ptr_in;
   logic [2:0] rd_ptr_ff, rd_ptr_in;
   logic [3:0] count_ff, count_in;

   logic       req_accept;
   logic       rsp_accept;
   result_type res [MAX_RESULTS];
   logic [1:0] n_res;

   // Combinational decode of one item.
   logic [7:0]  cnt;
   logic [13:0] shifted;
   logic [6:0]  sept_a;
   logic [6:0]  carry_new;
   logic [7:0]  left_a;
   logic [7:0]  left_b;

   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = rsp_valid && !rsp_stall;

   // Room for a full burst of three results must be there before an item is taken.
   assign req_stall = (count_ff > 4'd5);
   assign csr_ready = 1'b1;

   assign rsp_valid     = (count_ff != 4'd0);
   assign rsp_character = queue_ff[rd_ptr_ff].character;
   assign rsp_last      = queue_ff[rd_ptr_ff].last;

   always_comb begin
      cnt       = (req_octet < max_chars_ff) ? req_octet : max_chars_ff;
      shifted   = {6'd0, req_octet} << phase_ff;
      // New bits sit above the carried ones; the bits pushed past seven carry on.
      sept_a    = shifted[6:0] | carry_ff;
      carry_new = shifted[13:7];
      left_a    = left_ff - 8'd1;
      left_b    = left_a - 8'd1;

      carry_in  = carry_ff;
      phase_in  = phase_ff;
      left_in   = left_ff;
      active_in = active_ff;
      n_res     = 2'd0;
      for (int i = 0; i < MAX_RESULTS; i++) begin
         res[i] = '0;
      end

      if (req_accept) begin
         if (req_is_header) begin
            carry_in = 7'd0;
            phase_in = 3'd0;
            left_in  = cnt;
            if (cnt == 8'd0) begin
               active_in = 1'b0;
               res[0]    = '{character: 8'd0, last: 1'b1};
               n_res     = 2'd1;
            end else begin
               active_in = 1'b1;
            end
         end else if (active_ff) begin
            res[0]   = '{character: SEPTET_ROM[sept_a], last: 1'b0};
            n_res    = 2'd1;
            left_in  = left_a;
            carry_in = carry_new;
            phase_in = phase_ff + 3'd1;
            if (left_a == 8'd0) begin
               // Count used up: the terminator follows at once.
               res[1]    = '{character: 8'd0, last: 1'b1};
               n_res     = 2'd2;
               active_in = 1'b0;
            end
            if (phase_ff == LAST_PHASE) begin
               // End of a group: the carried bits form an eighth septet.
               if (left_a != 8'd0) begin
                  res[1]  = '{character: SEPTET_ROM[carry_new], last: 1'b0};
                  n_res   = 2'd2;
                  left_in = left_b;
                  if (left_b == 8'd0) begin
                     res[2]    = '{character: 8'd0, last: 1'b1};
                     n_res     = 2'd3;
                     active_in = 1'b0;
                  end
               end
               carry_in = 7'd0;
               phase_in = 3'd0;
            end
         end
      end

      max_chars_in = (csr_valid && csr_ready) ? csr_data : max_chars_ff;
      wr_ptr_in    = wr_ptr_ff + {1'b0, n_res};
      rd_ptr_in    = rd_ptr_ff + {2'd0, rsp_accept};
      count_in     = count_ff + {2'd0, n_res} - {3'd0, rsp_accept};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_chars_ff <= MAX_CHARS_RESET;
         carry_ff     <= 7'd0;
         phase_ff     <= 3'd0;
         left_ff      <= 8'd0;
         active_ff    <= 1'b0;
         wr_ptr_ff    <= 3'd0;
         rd_ptr_ff    <= 3'd0;
         count_ff     <= 4'd0;
      end else begin
         max_chars_ff <= max_chars_in;
         carry_ff     <= carry_in;
         phase_ff     <= phase_in;
         left_ff      <= left_in;
         active_ff    <= active_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         count_ff     <= count_in;
      end
   end

   // Queue payload needs no reset.
   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
         if (i < int'(n_res)) begin
            queue_ff[wr_ptr_ff + 3'(i)] <= res[i];
         end
      end
   end

endmodule

### verif/tb_gsm_septet_unpacker_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the GSM septet unpacker
// Drives headers and packed octets with random gaps and receiver stalls, and
// predicts every character and terminator item. Each accepted result item is
// compared field by field with the oldest prediction. The character limit is
// changed between phases, once the block has drained.
// ----------------------------------------------------------------------------
module tb_gsm_septet_unpacker_unit;
   import gsu_pkg::*;

   localparam int CLOCK_HIGH    = 6;
   localparam int CLOCK_LOW     = 6;
   localparam int RESET_CYCLES  = 9;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int PHASE_ITEMS   = 25;
   localparam int MAX_OCTETS    = 40;
   localparam int IDLE_PERCENT  = 29;
   localparam int HOLD_CYCLES   = 80;
   localparam int SETTLE_CYCLES = 4;

   // Tracks the decoder state of the block and keeps the characters it owes.
   class gsm_char_tracker;
      result_type  owed_chars[$];
      logic [7:0]  char_limit;
      logic [6:0]  carry;
      logic [2:0]  phase;
      logic [7:0]  chars_left;
      bit          active;
      int unsigned errors;

      function new();
         char_limit = MAX_CHARS_RESET;
         carry      = '0;
         phase      = '0;
         chars_left = '0;
         active     = 1'b0;
         errors     = 0;
      endfunction

      function void add_terminator();
         result_type item;
         item.character = 8'h00;
         item.last      = 1'b1;
         owed_chars.push_back(item);
         active = 1'b0;
      endfunction

      // One septet becomes one character; the terminator follows at once
      // when this was the last septet that the count allows.
      function void add_septet(logic [6:0] code);
         result_type item;
         item.character = SEPTET_ROM[code];
         item.last      = 1'b0;
         owed_chars.push_back(item);
         chars_left = chars_left - 8'd1;
         if (chars_left == 8'd0) begin
            add_terminator();
         end
      endfunction

      // Returns 1 when the item has an effect on the block, 0 when ignored.
      function bit decode_item(logic [7:0] octet, logic is_header);
         logic [7:0]  count;
         logic [14:0] joined;
         logic [2:0]  pos;
         if (is_header) begin
            count      = (octet < char_limit) ? octet : char_limit;
            carry      = '0;
            phase      = '0;
            chars_left = count;
            if (count == 8'd0) begin
               add_terminator();
            end else begin
               active = 1'b1;
            end
            return 1'b1;
         end
         if (!active) begin
            return 1'b0;
         end
         pos    = (phase > LAST_PHASE) ? LAST_PHASE : phase;
         joined = ({7'd0, octet} << pos) | {8'd0, carry};
         add_septet(joined[6:0]);
         carry = 7'(octet >> (7 - pos));
         if (pos == LAST_PHASE) begin
            // The seventh octet of a group leaves a whole septet behind.
            if (active) begin
               add_septet(carry);
            end
            carry = '0;
            phase = '0;
         end else begin
            phase = pos + 3'd1;
         end
         return 1'b1;
      endfunction

      function void check_char(logic [7:0] character, logic last);
         result_type due;
         if (owed_chars.size() == 0) begin
            $error("unexpected result item: character %h, last %b", character, last);
            errors++;
            return;
         end
         due = owed_chars.pop_front();
         if (character !== due.character) begin
            $error("character: expected %h, actual %h", due.character, character);
            errors++;
         end
         if (last !== due.last) begin
            $error("last: expected %b, actual %b", due.last, last);
            errors++;
         end
      endfunction

      function int pending();
         return owed_chars.size();
      endfunction
   endclass

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_octet;
   logic       req_is_header;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [7:0] rsp_character;
   logic       rsp_last;
   logic       csr_valid;
   logic       csr_ready;
   logic [7:0] csr_data;

   gsm_char_tracker tracker = new();

   // Items that reached the decoder, as opposed to octets dropped while idle.
   int unsigned decoded_items = 0;
   int unsigned cycle_count   = 0;
   // While set, neither side idles: a long stretch at full rate.
   bit          steady_run    = 1'b0;
   // Cycles for which the receiver still has to hold off completely.
   int          hold_left     = 0;

   gsm_septet_unpacker_unit DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_octet     (req_octet),
      .req_is_header (req_is_header),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_data      (csr_data)
   );

   initial clock = 1'b0;
   always begin
      #CLOCK_HIGH clock = 1'b1;
      #CLOCK_LOW  clock = 1'b0;
   end

   // The run is ended here if the block ever stops making progress.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_gsm_septet_unpacker_unit: errors");
         $finish;
      end
   end

   // Result items are taken at the rising edge when valid is high and we are
   // not stalling. Stall itself only ever changes at the falling edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         tracker.check_char(rsp_character, rsp_last);
      end
   end

   // Receiver: stalls at random, except during a steady stretch, and holds
   // off for a counted run of cycles when asked, so that the result queue
   // fills and the block has to stall its input.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= !steady_run && ($urandom_range(0, 99) < IDLE_PERCENT);
         end
      end
   end

   // Offers one item, with random idle cycles ahead of it, and returns at the
   // rising edge that accepts it. Each falling edge assigns valid only once.
   task automatic send_item(input logic [7:0] octet, input logic is_header);
      while (!steady_run && $urandom_range(0, 99) < IDLE_PERCENT) begin
         @(negedge clock);
         req_valid <= 1'b0;
         @(posedge clock);
      end
      @(negedge clock);
      req_valid     <= 1'b1;
      req_octet     <= octet;
      req_is_header <= is_header;
      do @(posedge clock); while (req_stall);
      if (tracker.decode_item(octet, is_header)) begin
         decoded_items++;
      end
   endtask

   // The sender waits until every owed item has come out, then allows the
   // block a few cycles to finish any octet that gave no result.
   task automatic wait_drained();
      while (tracker.pending() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // The limit register is only written while the block is idle. The last
   // item is withdrawn first so that it is not taken a second time.
   task automatic write_limit(input logic [7:0] value);
      @(negedge clock);
      req_valid <= 1'b0;
      wait_drained();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      tracker.char_limit = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // One random burst of traffic. Mostly whole messages with random content
   // and just enough octets, sometimes a couple of spare octets that must be
   // dropped; otherwise a stray octet, or a message cut short by a header.
   // Very long messages are cut short after a fixed number of octets.
   task automatic send_message();
      int kind;
      int count;
      int effective;
      int octets;
      int k;
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
         send_item(8'($urandom_range(0, 255)), 1'b0);
      end else if (kind < 15) begin
         count = $urandom_range(1, 40);
         send_item(8'(count), 1'b1);
         repeat ($urandom_range(0, count / 2)) send_item(8'($urandom_range(0, 255)), 1'b0);
      end else begin
         if (kind < 80) begin
            count = $urandom_range(0, 40);
         end else if (kind < 96) begin
            // A count at or above the limit, so that the cap is exercised.
            count = tracker.char_limit + $urandom_range(0, 20);
            if (count > 255) begin
               count = 255;
            end
         end else begin
            count = $urandom_range(0, 255);
         end
         effective = (count < tracker.char_limit) ? count : tracker.char_limit;
         // Seven octets carry eight septets.
         octets = (7 * effective + 7) / 8 + $urandom_range(0, 2);
         if (octets > MAX_OCTETS) begin
            octets = MAX_OCTETS;
         end
         send_item(8'(count), 1'b1);
         for (k = 0; k < octets; k++) begin
            send_item(8'($urandom_range(0, 255)), 1'b0);
         end
      end
   endtask

   task automatic run_phase(input logic [7:0] value, input int unsigned items);
      int unsigned target;
      write_limit(value);
      target = decoded_items + items;
      while (decoded_items < target) begin
         send_message();
      end
   endtask

   initial begin
      int k;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_octet     = 8'h00;
      req_is_header = 1'b0;
      csr_valid     = 1'b0;
      csr_data      = 8'h00;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed items, with the limit at its reset value.
      // An octet while idle is dropped without a result.
      send_item(8'h55, 1'b0);
      // A count of zero yields the terminator alone.
      send_item(8'h00, 1'b1);
      // The escape septet has no Latin-1 form.
      send_item(8'h01, 1'b1);
      send_item(8'h1B, 1'b0);
      // A full group of seven octets: the last one gives two characters and
      // then the terminator.
      send_item(8'h08, 1'b1);
      send_item(8'hFF, 1'b0);
      send_item(8'h00, 1'b0);
      send_item(8'hFF, 1'b0);
      send_item(8'h00, 1'b0);
      send_item(8'h80, 1'b0);
      send_item(8'h7F, 1'b0);
      send_item(8'hAA, 1'b0);
      // A count above the limit, abandoned by a fresh header. The count of
      // seven runs out on the last octet of the group, so the carried septet
      // is not emitted.
      send_item(8'hFF, 1'b1);
      send_item(8'h07, 1'b1);
      for (k = 0; k < 7; k++) begin
         send_item(8'($urandom_range(0, 255)), 1'b0);
      end
      send_item(8'h7E, 1'b0);

      // Random phases over a spread of limits, zero and 254 among them.
      steady_run = 1'b1;
      run_phase(8'd254, PHASE_ITEMS);
      steady_run = 1'b0;
      run_phase(8'd0, PHASE_ITEMS);
      run_phase(8'd1, PHASE_ITEMS);
      write_limit(8'd7);
      // The receiver now holds off for a long stretch while items keep
      // arriving, which fills the result queue and stalls the input side.
      @(posedge clock);
      hold_left = HOLD_CYCLES;
      run_phase(8'd7, PHASE_ITEMS);
      run_phase(8'd8, PHASE_ITEMS);
      run_phase(8'($urandom_range(2, 30)), PHASE_ITEMS);
      run_phase(MAX_CHARS_RESET, PHASE_ITEMS);
      run_phase(8'd3, PHASE_ITEMS);

      @(negedge clock);
      req_valid <= 1'b0;
      wait_drained();
      if (tracker.errors == 0 && tracker.pending() == 0) begin
         $display("tb_gsm_septet_unpacker_unit: clean");
      end else begin
         $display("tb_gsm_septet_unpacker_unit: errors");
      end
      $finish;
   end

endmodule
